// ----- hdl/cfl_pkg.sv -----
// ----------------------------------------------------------------------------
// cfl_pkg: shared types and constants
// Widths, register indexes and the front-to-back item record.
// ----------------------------------------------------------------------------
`default_nettype none
package cfl_pkg;
	localparam int unsigned HeightW = 16;
	localparam int unsigned MomW    = 24;
	localparam int unsigned SpeedW  = 24;
	localparam int unsigned CfgW    = 16;
	localparam int unsigned IdxW    = 1;
	localparam int unsigned QueueDepth = 2;

	localparam logic [IdxW-1:0] RegGravity   = 1'b0;
	localparam logic [IdxW-1:0] RegCellWidth = 1'b1;

	localparam logic [SpeedW-1:0] Sat24 = '1;

	// One classified cell as handed from front to back.
	typedef struct packed {
		logic [HeightW-1:0] height;
		logic [MomW-2:0]    mag_lo;
		logic               mag_top;
		logic               last;
	} cell_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_VEL,
		ST_SQRT,
		ST_ACC,
		ST_STEP,
		ST_OUT
	} back_state_t;
endpackage
`default_nettype wire

// ----- hdl/cfl_front.sv -----
// ----------------------------------------------------------------------------
// cfl_front: input stage
// Accepts cells, forms the momentum magnitude and pushes items into a queue.
// ----------------------------------------------------------------------------
`default_nettype none
module cfl_front
	import cfl_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [HeightW-1:0]  cell_height,
	input  wire logic [MomW-1:0]     cell_momentum,
	input  wire logic                last_cell,
	output logic                     q_valid,
	input  wire logic                q_pop,
	output cell_item_t               q_item
);
	localparam int unsigned PtrW = $clog2(QueueDepth);

	cell_item_t             mem_q [QueueDepth];
	logic [PtrW-1:0]        wr_q, rd_q;
	logic [PtrW:0]          cnt_q;
	logic [MomW:0]          mag;
	cell_item_t             item;
	logic                   push;

	// Magnitude can reach 2^23, which still fits in the MomW-bit field.
	always_comb begin
		if (cell_momentum[MomW-1]) begin
			mag = (MomW+1)'(1 << MomW) - {1'b0, cell_momentum};
		end else begin
			mag = {1'b0, cell_momentum};
		end
		item.height  = cell_height;
		item.mag_lo  = mag[MomW-2:0];
		item.mag_top = mag[MomW-1];
		item.last    = last_cell;
	end

	assign in_ready = (cnt_q != (PtrW+1)'(QueueDepth));
	assign push     = in_valid && in_ready;
	assign q_valid  = (cnt_q != '0);
	assign q_item   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (q_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (PtrW+1)'(push) - (PtrW+1)'(q_pop);
		end
	end
endmodule
`default_nettype wire

// ----- hdl/cfl_back.sv -----
// ----------------------------------------------------------------------------
// cfl_back: arithmetic sequencer
// Bit-serial divides and square root, running maximum and output register.
// ----------------------------------------------------------------------------
`default_nettype none
module cfl_back
	import cfl_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                q_valid,
	output logic                     q_pop,
	input  wire cell_item_t          q_item,
	input  wire logic [CfgW-1:0]     gravity,
	input  wire logic [CfgW-1:0]     cell_width,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [SpeedW-1:0]        time_step,
	output logic                     no_motion
);
	// Division width: numerator up to 40 bits.
	localparam int unsigned NumW = 40;
	localparam int unsigned CntW = 6;

	back_state_t        state_q, state_d;
	logic [NumW-1:0]    num_q;
	logic [NumW-1:0]    quo_q;
	logic [SpeedW:0]    rem_q;
	logic [SpeedW-1:0]  den_q;
	logic [CntW-1:0]    cnt_q;
	logic [31:0]        sv_q;
	logic [31:0]        sres_q;
	logic [31:0]        sbit_q;
	logic [SpeedW-1:0]  vel_q;
	logic [SpeedW-1:0]  max_q;
	logic               last_q;
	logic [SpeedW-1:0]  ts_q;
	logic               nm_q;

	logic [SpeedW+1:0]  rem_sh;
	logic [SpeedW+1:0]  rem_sub;
	logic [31:0]        trial;
	logic [SpeedW:0]    speed_sum;
	logic [SpeedW-1:0]  speed;
	logic [31:0]        gh;

	assign rem_sh  = {rem_q, num_q[NumW-1]};
	assign rem_sub = rem_sh - {2'b00, den_q};
	assign trial   = sres_q + sbit_q;
	assign speed_sum = {1'b0, vel_q} + {9'd0, sres_q[15:0]};
	assign speed   = speed_sum[SpeedW] ? Sat24 : speed_sum[SpeedW-1:0];
	assign gh      = 32'(gravity) * 32'(q_item.height);

	assign q_pop     = (state_q == ST_IDLE) && q_valid;
	assign out_valid = (state_q == ST_OUT);
	assign time_step = ts_q;
	assign no_motion = nm_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (q_valid) state_d = ST_VEL;
			ST_VEL:  if (cnt_q == '0) state_d = ST_SQRT;
			// The iteration with the lowest bit pair is the last one.
			ST_SQRT: if (sbit_q == 32'd1) state_d = ST_ACC;
			ST_ACC:  state_d = last_q ? ST_STEP : ST_IDLE;
			ST_STEP: if (cnt_q == '0) state_d = ST_OUT;
			ST_OUT:  if (out_ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			max_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_ACC && speed > max_q) begin
				max_q <= speed;
			end
			if (state_q == ST_STEP && cnt_q == '0) begin
				max_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				num_q  <= {8'd0, q_item.mag_top, q_item.mag_lo, 8'd0};
				den_q  <= {8'd0, q_item.height};
				rem_q  <= '0;
				quo_q  <= '0;
				cnt_q  <= CntW'(NumW - 1);
				last_q <= q_item.last;
				sv_q   <= gh;
				sres_q <= '0;
				sbit_q <= 32'h4000_0000;
			end
			ST_VEL: begin
				// Restoring divide, one quotient bit per cycle.
				num_q <= num_q << 1;
				if (!rem_sub[SpeedW+1]) begin
					rem_q <= rem_sub[SpeedW:0];
					quo_q <= {quo_q[NumW-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh[SpeedW:0];
					quo_q <= {quo_q[NumW-2:0], 1'b0};
				end
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					if (den_q == '0) begin
						vel_q <= '0;
					end else if (rem_sub[SpeedW+1] ? (quo_q[NumW-2:SpeedW-1] != '0)
						: (quo_q[NumW-2:SpeedW-1] != '0)) begin
						vel_q <= Sat24;
					end else begin
						vel_q <= {quo_q[SpeedW-2:0], ~rem_sub[SpeedW+1]};
					end
				end
			end
			ST_SQRT: begin
				// Bit-pair square root, one result bit per cycle.
				if (sv_q >= trial) begin
					sv_q   <= sv_q - trial;
					sres_q <= (sres_q >> 1) + sbit_q;
				end else begin
					sres_q <= sres_q >> 1;
				end
				sbit_q <= sbit_q >> 2;
			end
			ST_ACC: begin
				num_q <= {cell_width, 24'd0};
				den_q <= (speed > max_q) ? speed : max_q;
				rem_q <= '0;
				quo_q <= '0;
				cnt_q <= CntW'(NumW - 1);
			end
			ST_STEP: begin
				num_q <= num_q << 1;
				if (!rem_sub[SpeedW+1]) begin
					rem_q <= rem_sub[SpeedW:0];
					quo_q <= {quo_q[NumW-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh[SpeedW:0];
					quo_q <= {quo_q[NumW-2:0], 1'b0};
				end
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					// Numerator is cell_width * 2^24; the step is quotient >> 8.
					nm_q <= (den_q == '0);
					if (den_q == '0) begin
						ts_q <= Sat24;
					end else if (quo_q[NumW-2:SpeedW+7] != '0) begin
						ts_q <= Sat24;
					end else begin
						ts_q <= quo_q[SpeedW+6:7];
					end
				end
			end
			default: begin
				cnt_q <= cnt_q;
			end
		endcase
	end
endmodule
`default_nettype wire

// ----- hdl/cfl_time_step_limit_top.sv -----
// ----------------------------------------------------------------------------
// cfl_time_step_limit_top: CFL time step for a 1-D shallow-water grid
// Streams cells, keeps the maximum wave speed and emits dx / peak speed.
// ----------------------------------------------------------------------------
// Usage: cells arrive on the in channel (valid/ready) as cell_height,
// cell_momentum and last_cell. Each cell item is held in a two-entry queue
// and then worked by the back end: a bit-serial divide for the velocity, a
// bit-pair square root for the celerity and an ST_ACC step to update the
// running maximum; both divides use the single shared shift-subtract
// divider, and the back end takes the next cell only once it is idle. A
// last cell adds a second divide for the step and then presents one result
// item on the out channel (time_step, no_motion). It stays there until
// out_ready, and the queue goes on taking cells meanwhile until it fills.
// The maximum clears after each run. Reset sets gravity to 2511, cell_width
// to 256 and the maximum to zero. The cfg channel writes gravity (index 0)
// or cell_width (index 1) and is always ready.
// ----------------------------------------------------------------------------
`default_nettype none
module cfl_time_step_limit_top
	import cfl_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [HeightW-1:0]  cell_height,
	input  wire logic [MomW-1:0]     cell_momentum,
	input  wire logic                last_cell,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [SpeedW-1:0]        time_step,
	output logic                     no_motion,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [IdxW-1:0]     cfg_index,
	input  wire logic [CfgW-1:0]     cfg_data
);
	logic              q_valid, q_pop;
	cell_item_t        q_item;
	logic [CfgW-1:0]   gravity_q, cell_width_q;

	assign cfg_ready = 1'b1;

	// Register file for the two configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gravity_q    <= CfgW'(2511);
			cell_width_q <= CfgW'(256);
		end else if (cfg_valid) begin
			case (cfg_index)
				RegGravity:   gravity_q    <= cfg_data;
				RegCellWidth: cell_width_q <= cfg_data;
				default:      gravity_q    <= gravity_q;
			endcase
		end
	end

	cfl_front u_front (
		.clk, .arst_n, .in_valid, .in_ready, .cell_height, .cell_momentum,
		.last_cell, .q_valid, .q_pop, .q_item
	);

	cfl_back u_back (
		.clk, .arst_n, .q_valid, .q_pop, .q_item,
		.gravity(gravity_q), .cell_width(cell_width_q),
		.out_valid, .out_ready, .time_step, .no_motion
	);
endmodule
`default_nettype wire

// ----- bench/cfl_time_step_limit_top_tb.sv -----
// ----------------------------------------------------------------------------
// cfl_time_step_limit_top_tb: self-checking bench for the CFL time step block
// Streams grid cells with random bursts and stalls, predicts each run's time
// step in a behavioral model and compares every result item as it arrives.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module cfl_time_step_limit_top_tb;
	import cfl_pkg::*;

	localparam int Sat = 24'hFFFFFF;
	localparam int WatchLimit = 20000;

	// One cell as offered on the input channel.
	typedef struct packed {
		logic [HeightW-1:0] height;
		logic [MomW-1:0]    momentum;
		logic               last;
	} cell_t;

	// One expected result item.
	typedef struct packed {
		logic [SpeedW-1:0] step;
		logic              still;
	} step_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [HeightW-1:0] cell_height;
	logic [MomW-1:0] cell_momentum;
	logic last_cell;
	logic out_valid;
	logic out_ready;
	logic [SpeedW-1:0] time_step;
	logic no_motion;
	logic cfg_valid;
	logic cfg_ready;
	logic [IdxW-1:0] cfg_index;
	logic [CfgW-1:0] cfg_data;

	cfl_time_step_limit_top DUT (.*);

	// Predictor state: a copy of the registers and the running maximum.
	logic [CfgW-1:0] grav_model;
	logic [CfgW-1:0] dx_model;
	logic [SpeedW-1:0] peak_speed;

	cell_t pending_cells[$];
	step_t expected_steps[$];
	int mismatches;
	int idle_cycles;
	bit hold_off_req;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Integer square root by the bit-pair method.
	function automatic logic [31:0] root32(input logic [31:0] v);
		logic [31:0] r;
		logic [31:0] b;
		r = 0;
		b = 32'h4000_0000;
		while (b > v)
			b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// Fold one accepted cell into the maximum; on a last cell queue the step.
	task automatic predict_cell(input cell_t c);
		logic [23:0] mag;
		logic [63:0] vel;
		logic [63:0] spd;
		logic [63:0] dt;
		step_t s;
		mag = c.momentum[23] ? 24'(-c.momentum) : c.momentum;
		// The most negative momentum has magnitude 2^23, which still fits 24 bits.
		vel = 0;
		if (c.height != 0) begin
			vel = ({40'd0, mag} << 8) / c.height;
			if (vel > Sat)
				vel = Sat;
		end
		spd = vel + root32(32'(grav_model) * 32'(c.height));
		if (spd > Sat)
			spd = Sat;
		if (spd[23:0] > peak_speed)
			peak_speed = spd[23:0];
		if (c.last) begin
			if (peak_speed == 0) begin
				s.step = 24'(Sat);
				s.still = 1'b1;
			end else begin
				dt = ({48'd0, dx_model} << 16) / peak_speed;
				s.step = (dt > Sat) ? 24'(Sat) : dt[23:0];
				s.still = 1'b0;
			end
			expected_steps.push_back(s);
			peak_speed = '0;
		end
	endtask

	// Driver: bursts of random length separated by random gaps.
	int burst_left;
	int gap_left;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			cell_height <= '0;
			cell_momentum <= '0;
			last_cell <= 1'b0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			if (in_valid && in_ready) begin
				predict_cell({cell_height, cell_momentum, last_cell});
			end
			if (!in_valid || in_ready) begin
				if (burst_left == 0 && gap_left == 0) begin
					burst_left = $urandom_range(1, 30);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 80);
				end
				if (burst_left == 0) begin
					gap_left = gap_left - 1;
					in_valid <= 1'b0;
				end else if (pending_cells.size() > 0) begin
					cell_t c;
					c = pending_cells.pop_front();
					in_valid <= 1'b1;
					cell_height <= c.height;
					cell_momentum <= c.momentum;
					last_cell <= c.last;
					burst_left = burst_left - 1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver stall pattern, with an optional long hold-off counted here.
	int stall_phase;
	int hold_count;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_phase = 0;
			hold_count = 0;
		end else begin
			if (hold_off_req && hold_count == 0)
				hold_count = 3000;
			if (hold_count > 0) begin
				hold_count = hold_count - 1;
				if (hold_count == 0)
					hold_off_req = 1'b0;
				out_ready <= 1'b0;
			end else begin
				stall_phase = (stall_phase + 1) % 64;
				if (stall_phase < 16)
					out_ready <= 1'b1;
				else
					out_ready <= ($urandom_range(0, 2) != 0);
			end
		end
	end

	// Monitor: compare each result item against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_steps.size() == 0) begin
					mismatches = mismatches + 1;
					if (mismatches <= 10)
						$display("unexpected result item: time_step=%h no_motion=%b",
							time_step, no_motion);
				end else begin
					step_t e;
					e = expected_steps.pop_front();
					if (e.step !== time_step || e.still !== no_motion) begin
						mismatches = mismatches + 1;
						if (mismatches <= 10)
							$display("mismatch: time_step exp %h got %h, no_motion exp %b got %b",
								e.step, time_step, e.still, no_motion);
					end
				end
			end
			if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_valid)
				idle_cycles = 0;
			else
				idle_cycles = idle_cycles + 1;
			if (idle_cycles >= WatchLimit) begin
				$display("cfl_time_step_limit_top verification failed");
				$finish;
			end
		end
	end

	// Build one cell with random content; momentum bits span the full word.
	function automatic cell_t rand_cell(input bit last);
		cell_t c;
		case ($urandom_range(0, 5))
			0: c.height = '0;
			1: c.height = 16'($urandom_range(1, 4));
			2: c.height = 16'hFFFF - 16'($urandom_range(0, 3));
			default: c.height = 16'($urandom);
		endcase
		case ($urandom_range(0, 4))
			0: c.momentum = $urandom_range(0, 1) ? 24'h800000 : 24'h7FFFFF;
			1: c.momentum = 24'($signed($urandom_range(0, 2000)) - 1000);
			default: c.momentum = 24'($urandom);
		endcase
		c.last = last;
		return c;
	endfunction

	task automatic add_cell(input logic [15:0] h, input logic [23:0] m, input bit l);
		cell_t c;
		c.height = h;
		c.momentum = m;
		c.last = l;
		pending_cells.push_back(c);
	endtask

	// Wait until all queued items are taken and all results are back.
	task automatic drain;
		while (pending_cells.size() > 0 || in_valid || expected_steps.size() > 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	// Write one register while the block is idle.
	task automatic write_reg(input logic [IdxW-1:0] idx, input logic [CfgW-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		if (idx == RegGravity)
			grav_model = val;
		else
			dx_model = val;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Random runs of short grids, mostly small, a few long.
	task automatic random_runs(input int n_items);
		int len;
		while (n_items > 0) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
			for (int i = 0; i < len; i++)
				pending_cells.push_back(rand_cell(i == len - 1));
			n_items = n_items - len;
		end
	endtask

	initial begin
		logic [CfgW-1:0] grav_set[5];
		logic [CfgW-1:0] dx_set[5];
		in_valid = 1'b0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		cell_height = '0;
		cell_momentum = '0;
		last_cell = 1'b0;
		mismatches = 0;
		idle_cycles = 0;
		hold_off_req = 0;
		grav_model = 16'd2511;
		dx_model = 16'd256;
		peak_speed = '0;
		grav_set = '{16'd0, 16'hFFFF, 16'd1, 16'd2511, 16'h0000};
		dx_set = '{16'd1, 16'hFFFF, 16'd256, 16'h8000, 16'h5555};
		grav_set[4] = 16'hAAAA;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: zero motion, extremes of height and momentum, saturation.
		add_cell(16'd0, 24'd0, 1'b1);
		add_cell(16'd0, 24'h7FFFFF, 1'b1);
		add_cell(16'd1, 24'h7FFFFF, 1'b1);
		add_cell(16'd1, 24'h800000, 1'b1);
		add_cell(16'hFFFF, 24'hFFFFFF, 1'b0);
		add_cell(16'hFFFF, 24'd1, 1'b1);
		add_cell(16'd256, 24'd256, 1'b0);
		add_cell(16'd512, 24'hFFFF00, 1'b0);
		add_cell(16'd128, 24'd0, 1'b1);
		add_cell(16'd0, 24'h800000, 1'b0);
		add_cell(16'd0, 24'd5, 1'b1);
		drain();

		// Gravity zero with a zero speed makes the step saturate.
		write_reg(RegGravity, 16'd0);
		write_reg(RegCellWidth, 16'hFFFF);
		add_cell(16'hFFFF, 24'd1, 1'b1);
		add_cell(16'd1, 24'd0, 1'b1);
		add_cell(16'd2, 24'h7FFFFF, 1'b1);
		drain();

		// Long hold-off on the receiver while cells keep coming.
		hold_off_req = 1'b1;
		for (int i = 0; i < 12; i++)
			pending_cells.push_back(rand_cell(1'b1));
		drain();

		for (int p = 0; p < 5; p++) begin
			write_reg(RegGravity, grav_set[p]);
			write_reg(RegCellWidth, dx_set[p]);
			random_runs(240);
			drain();
		end

		if (mismatches == 0)
			$display("cfl_time_step_limit_top verification clean");
		else
			$display("cfl_time_step_limit_top verification failed");
		$finish;
	end
endmodule
`default_nettype wire

// ----- sim.f -----
hdl/cfl_pkg.sv
hdl/cfl_front.sv
hdl/cfl_back.sv
hdl/cfl_time_step_limit_top.sv
bench/cfl_time_step_limit_top_tb.sv
